/* rtl/core/pcr_pkg.sv */
// shared types, constants and state codes for the collinear vertex removal block
package pcr_pkg;

  // field widths
  localparam int COORD_W  = 24;
  localparam int THRESH_W = 24;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = COORD_W + DIFF_W;
  localparam int AREA_W   = PROD_W + 2;
  localparam int TDATA_W  = 2 * COORD_W;

  // ring sizing
  localparam int MAX_POINTS_DEF = 64;
  localparam int MIN_RING       = 3;

  // register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_AREA_THRESHOLD = 1'b0;
  localparam logic [THRESH_W-1:0]   THRESH_RESET       = 24'd7;

  // controller states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_RD,
    ST_WT,
    ST_DIFF,
    ST_MUL,
    ST_SUM,
    ST_DEC,
    ST_E_RD,
    ST_E_WT,
    ST_E_HOLD
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_en;
    logic start;
    logic rd_c;
    logic cap_c;
    logic diff_en;
    logic mul_en;
    logic sum_en;
    logic decide;
    logic emit_skip;
    logic emit_cap;
    logic emit_adv;
    logic finish;
    logic out_valid;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_in;
    logic short_ring;
    logic walk_cont;
    logic emit_done;
    logic emit_dead;
    logic out_taken;
  } stat_t;

endpackage

/* rtl/core/polygon_collinear_point_removal_top.sv */
// top level: threshold register, controller and datapath of the collinear vertex remover
// Vertices load at one word per cycle; the word marked last starts the ring walk, or
// emission at once for under three vertices. Each walk step (one vertex examined) uses
// the single store read port and the diff / multiply / sum / decide chain; steps <=
// vertices + removals. Emission reads, registers and offers each kept vertex until
// taken, skipping removed ones. Reset clears the controller, vertex count, overflow
// flag and removal marks and sets area_threshold to 7; the vertex store is not cleared.
module polygon_collinear_point_removal_top #(
  parameter int MAX_POINTS = pcr_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pcr_pkg::TDATA_W-1:0]     s_tdata,   // point_x, point_y
  input  logic                            s_tlast,
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pcr_pkg::TDATA_W-1:0]     m_tdata,   // kept_x, kept_y
  output logic                            m_tlast,
  output logic                            m_tuser,   // overflowed
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pcr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pcr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import pcr_pkg::*;

  logic [THRESH_W-1:0] area_threshold;
  logic                reg_sel;
  cmd_t                cmd;
  stat_t               stat;

  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_AREA_THRESHOLD);
  assign pready  = 1'b1;

  // threshold register write
  always_ff @(posedge clk) begin
    if (rst) begin
      area_threshold <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      area_threshold <= pwdata[THRESH_W-1:0];
    end
  end

  // register read
  assign prdata = reg_sel ? APB_DATA_W'(area_threshold) : '0;

  pcr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  pcr_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .area_threshold (area_threshold),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser)
  );

endmodule

/* rtl/core/pcr_ram.sv */
// generic single-write, single-read ram with registered read data
module pcr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/pcr_ctrl.sv */
// controller state machine: load, ring walk and emission sequencing
module pcr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  pcr_pkg::stat_t stat,
  output pcr_pkg::cmd_t  cmd
);

  import pcr_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (stat.last_in) state_next = ST_START;
      end
      ST_START: begin
        state_next = stat.short_ring ? ST_E_RD : ST_RD;
      end
      ST_RD:   state_next = ST_WT;
      ST_WT:   state_next = ST_DIFF;
      ST_DIFF: state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_DEC;
      ST_DEC: begin
        state_next = stat.walk_cont ? ST_RD : ST_E_RD;
      end
      ST_E_RD: begin
        if (stat.emit_done) begin
          state_next = ST_LOAD;
        end else if (!stat.emit_dead) begin
          state_next = ST_E_WT;
        end
      end
      ST_E_WT: state_next = ST_E_HOLD;
      ST_E_HOLD: begin
        if (stat.out_taken) state_next = ST_E_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_LOAD:  cmd.load_en = 1'b1;
      ST_START: cmd.start   = 1'b1;
      ST_RD:    cmd.rd_c    = 1'b1;
      ST_WT:    cmd.cap_c   = 1'b1;
      ST_DIFF:  cmd.diff_en = 1'b1;
      ST_MUL:   cmd.mul_en  = 1'b1;
      ST_SUM:   cmd.sum_en  = 1'b1;
      ST_DEC:   cmd.decide  = 1'b1;
      ST_E_RD: begin
        cmd.finish    = stat.emit_done;
        cmd.emit_skip = !stat.emit_done && stat.emit_dead;
      end
      ST_E_WT:  cmd.emit_cap = 1'b1;
      ST_E_HOLD: begin
        cmd.out_valid = 1'b1;
        cmd.emit_adv  = stat.out_taken;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/pcr_dp.sv */
// datapath: vertex store, ring cursor, area arithmetic and output register
module pcr_dp #(
  parameter int MAX_POINTS = pcr_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pcr_pkg::cmd_t                 cmd,
  output pcr_pkg::stat_t                stat,
  input  logic [pcr_pkg::THRESH_W-1:0]  area_threshold,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pcr_pkg::TDATA_W-1:0]   s_tdata,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pcr_pkg::TDATA_W-1:0]   m_tdata,
  output logic                          m_tlast,
  output logic                          m_tuser
);

  import pcr_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  // load bookkeeping
  logic [CW-1:0]         count;
  logic                  ovf;
  logic [MAX_POINTS-1:0] dead;

  // walk cursor: n live vertices, cur compacted position, ib/sec original indices
  logic [CW-1:0] n;
  logic [CW-1:0] cur;
  logic [AW-1:0] ib;
  logic [AW-1:0] sec;
  logic [AW-1:0] ic;
  logic [CW:0]   cur_p1;

  // emission counters
  logic [CW-1:0] j;
  logic [CW-1:0] em;

  // coordinates of the current triple
  logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
  logic signed [DIFF_W-1:0]  d1, d2, d3;
  logic signed [PROD_W-1:0]  p1, p2, p3;
  logic signed [AREA_W-1:0]  area;
  logic signed [AREA_W-1:0]  thr_pos;
  logic signed [AREA_W-1:0]  thr_neg;
  logic                      collinear;

  // store ports
  logic                      s_fire;
  logic                      room;
  logic                      wr_en;
  logic [AW-1:0]             rd_addr;
  logic [COORD_W-1:0]        rd_x, rd_y;
  logic signed [COORD_W-1:0] in_x, in_y;

  // output register
  logic [COORD_W-1:0] kept_x, kept_y;
  logic               last_kept;

  assign in_x   = $signed(s_tdata[COORD_W-1:0]);
  assign in_y   = $signed(s_tdata[TDATA_W-1:COORD_W]);
  assign s_fire = s_tvalid && cmd.load_en;
  assign room   = (count < CW'(MAX_POINTS));
  assign wr_en  = s_fire && room;

  // successor of b: next original index, wrap to vertex 0, or the second vertex at ring end
  assign cur_p1 = {1'b0, cur} + (CW + 1)'(1);
  always_comb begin
    if (cur == n) begin
      ic = sec;
    end else if (cur_p1 < {1'b0, n}) begin
      ic = ib + AW'(1);
    end else begin
      ic = '0;
    end
  end

  assign rd_addr = cmd.rd_c ? ic : j[AW-1:0];

  pcr_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_store_x (
    .clk     (clk),
    .we      (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (s_tdata[COORD_W-1:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_x)
  );

  pcr_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_store_y (
    .clk     (clk),
    .we      (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (s_tdata[TDATA_W-1:COORD_W]),
    .rd_addr (rd_addr),
    .rd_data (rd_y)
  );

  // collinear test: |area| < threshold as two signed compares
  assign thr_pos   = $signed(AREA_W'(area_threshold));
  assign collinear = (area < thr_pos) && (area > thr_neg);

  // status
  always_comb begin
    stat            = '0;
    stat.last_in    = s_fire && s_tlast;
    stat.short_ring = (count < CW'(MIN_RING));
    stat.walk_cont  = collinear
                      ? ((cur <= n - CW'(1)) && (n - CW'(1) >= CW'(MIN_RING)))
                      : (cur_p1 <= {1'b0, n});
    stat.emit_done  = (j == count);
    stat.emit_dead  = dead[j[AW-1:0]];
    stat.out_taken  = m_tready;
  end

  // vertex count, overflow flag and removal marks
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      dead  <= '0;
    end else begin
      if (s_fire) begin
        if (room) begin
          count                <= count + CW'(1);
          dead[count[AW-1:0]]  <= 1'b0;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.decide && collinear) begin
        dead[ib] <= 1'b1;
      end
      if (cmd.finish) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // walk cursor and emission counters
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n   <= count;
      cur <= CW'(1);
      ib  <= AW'(1);
      j   <= '0;
      em  <= '0;
    end
    if (cmd.decide) begin
      ib <= ic;
      if (collinear) begin
        n <= n - CW'(1);
      end else begin
        cur <= cur + CW'(1);
        if (cur == CW'(1)) sec <= ib;
      end
    end
    if (cmd.emit_skip) begin
      j <= j + CW'(1);
    end
    if (cmd.emit_adv) begin
      j  <= j + CW'(1);
      em <= em + CW'(1);
    end
  end

  // triple coordinates: first two vertices captured on load, c fetched each step
  always_ff @(posedge clk) begin
    if (wr_en && count == CW'(0)) begin
      ax <= in_x;
      ay <= in_y;
    end
    if (wr_en && count == CW'(1)) begin
      bx <= in_x;
      by <= in_y;
    end
    if (cmd.cap_c) begin
      cx <= $signed(rd_x);
      cy <= $signed(rd_y);
    end
    if (cmd.decide) begin
      if (!collinear) begin
        ax <= bx;
        ay <= by;
      end
      bx <= cx;
      by <= cy;
    end
  end

  // doubled area: differences, products, sum
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      d1 <= DIFF_W'(by) - DIFF_W'(cy);
      d2 <= DIFF_W'(cy) - DIFF_W'(ay);
      d3 <= DIFF_W'(ay) - DIFF_W'(by);
    end
    if (cmd.mul_en) begin
      p1 <= ax * d1;
      p2 <= bx * d2;
      p3 <= cx * d3;
    end
    if (cmd.sum_en) begin
      area    <= AREA_W'(p1) + AREA_W'(p2) + AREA_W'(p3);
      thr_neg <= -thr_pos;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.emit_cap) begin
      kept_x    <= rd_x;
      kept_y    <= rd_y;
      last_kept <= (em == n - CW'(1));
    end
  end

  assign s_tready = cmd.load_en;
  assign m_tvalid = cmd.out_valid;
  assign m_tdata  = {kept_y, kept_x};
  assign m_tlast  = last_kept;
  assign m_tuser  = ovf;

endmodule

/* rtl/core/pcr_checker.sv */
// port-level checks for the collinear vertex remover, bound to the top level
module pcr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pcr_pkg::TDATA_W-1:0]     m_tdata,
  input logic                            m_tlast,
  input logic                            m_tuser,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [pcr_pkg::APB_ADDR_W-1:0]  paddr,
  input logic [pcr_pkg::APB_DATA_W-1:0]  pwdata,
  input logic [pcr_pkg::APB_DATA_W-1:0]  prdata,
  input logic                            pready
);

  import pcr_pkg::*;

  // a stalled output word holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output word changed while stalled");

  // no vertex is taken while a kept vertex is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while output valid");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a threshold write reads back at the threshold address
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1:2] == REG_AREA_THRESHOLD)
    |=> (paddr[APB_ADDR_W-1:2] != REG_AREA_THRESHOLD)
        || (prdata == APB_DATA_W'($past(pwdata[THRESH_W-1:0]))))
    else $error("threshold readback mismatch");

endmodule

bind polygon_collinear_point_removal_top pcr_checker u_pcr_checker (.*);
